### rtl/matrix_scan_order_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix scan order generator
// Shorthand for clocked implication checks with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef MATRIX_SCAN_ORDER_GENERATOR_MACROS_SVH
`define MATRIX_SCAN_ORDER_GENERATOR_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define MSOG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold on the following clock.
`define MSOG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/msog_pkg.sv
// ----------------------------------------------------------------------------
// msog_pkg
// Shared types and codes of the matrix scan order generator.
// ----------------------------------------------------------------------------
package msog_pkg;

  // Scan orders selected by the scan_mode register.
  typedef enum logic [1:0] {
    MODE_RASTER = 2'd0,
    MODE_SNAKE  = 2'd1,
    MODE_SPIRAL = 2'd2,
    MODE_SHELL  = 2'd3
  } scan_mode_t;

  // Walk leg codes. Spiral uses all four, shells use the first two.
  localparam logic [1:0] PH_RIGHT = 2'd0;
  localparam logic [1:0] PH_DOWN  = 2'd1;
  localparam logic [1:0] PH_LEFT  = 2'd2;
  localparam logic [1:0] PH_UP    = 2'd3;
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;

  // Register file layout.
  localparam int SIZE_W  = 7;
  localparam int MODE_W  = 2;
  localparam int RING_W  = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam logic REG_IDX_SIZE = 1'b0;
  localparam logic REG_IDX_MODE = 1'b1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

endpackage

### rtl/msog_cfg.sv
// ----------------------------------------------------------------------------
// msog_cfg
// APB register file holding the matrix side length and the scan order.
// ----------------------------------------------------------------------------
module msog_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msog_pkg::APB_AW-1:0]     paddr,
  input  logic [msog_pkg::APB_DW-1:0]     pwdata,
  output logic [msog_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output logic [msog_pkg::SIZE_W-1:0]     matrix_size,
  output logic [msog_pkg::MODE_W-1:0]     scan_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= msog_pkg::SIZE_RESET;
      scan_mode   <= msog_pkg::MODE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        msog_pkg::REG_IDX_SIZE: matrix_size <= pwdata[msog_pkg::SIZE_W-1:0];
        msog_pkg::REG_IDX_MODE: scan_mode   <= pwdata[msog_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      msog_pkg::REG_IDX_SIZE:
        prdata = {{(msog_pkg::APB_DW-msog_pkg::SIZE_W){1'b0}}, matrix_size};
      msog_pkg::REG_IDX_MODE:
        prdata = {{(msog_pkg::APB_DW-msog_pkg::MODE_W){1'b0}}, scan_mode};
      default:
        prdata = '0;
    endcase
  end

endmodule

### rtl/msog_step.sv
// ----------------------------------------------------------------------------
// msog_step
// Next-cell logic: from the held position, leg and count, work out the next
// cell of the selected order, or fall back to the first cell.
// ----------------------------------------------------------------------------
module msog_step #(
  parameter int MAX_SIZE = 64
) (
  input  logic [msog_pkg::SIZE_W-1:0]            matrix_size,
  input  logic [msog_pkg::MODE_W-1:0]            scan_mode,
  input  logic                                   restart,
  input  logic [$clog2(MAX_SIZE)-1:0]            cur_row,
  input  logic [$clog2(MAX_SIZE)-1:0]            cur_col,
  input  logic [1:0]                             leg_phase,
  input  logic [msog_pkg::RING_W-1:0]            ring_index,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0] visit_count,
  output logic [$clog2(MAX_SIZE)-1:0]            row_next,
  output logic [$clog2(MAX_SIZE)-1:0]            col_next,
  output logic [1:0]                             phase_next,
  output logic [msog_pkg::RING_W-1:0]            ring_next,
  output logic [$clog2(MAX_SIZE*MAX_SIZE+1)-1:0] count_next,
  output logic                                   last
);

  localparam int ROW_W = $clog2(MAX_SIZE);
  localparam int CW    = $clog2(MAX_SIZE * MAX_SIZE + 1);
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int SW    = ((ROW_W > msog_pkg::RING_W) ? ROW_W : msog_pkg::RING_W) + 3;

  logic [NW-1:0]          n;
  logic [2*NW-1:0]        prod;
  logic [CW-1:0]          total;
  logic                   start_in;
  logic                   ok;
  logic                   start;
  logic signed [SW-1:0]   n_s, r0, c0, k0, r, c, k, hi;
  logic [1:0]             ph;

  // Clamp the side length into 1..MAX_SIZE.
  always_comb begin
    if (matrix_size == '0) begin
      n = NW'(1);
    end else if (32'(matrix_size) > 32'(MAX_SIZE)) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(matrix_size);
    end
  end

  assign prod  = n * n;
  assign total = prod[CW-1:0];

  assign start_in = restart || (visit_count == '0) || (visit_count >= total) ||
                    ({1'b0, cur_row} >= (ROW_W+1)'(n)) ||
                    ({1'b0, cur_col} >= (ROW_W+1)'(n));

  assign n_s = $signed({{(SW-NW){1'b0}}, n});
  assign r0  = $signed({{(SW-ROW_W){1'b0}}, cur_row});
  assign c0  = $signed({{(SW-ROW_W){1'b0}}, cur_col});
  assign k0  = $signed({{(SW-msog_pkg::RING_W){1'b0}}, ring_index});
  assign hi  = n_s - k0 - SW'(1);

  always_comb begin
    r  = r0;
    c  = c0;
    k  = k0;
    ph = leg_phase;
    ok = 1'b1;
    case (msog_pkg::scan_mode_t'(scan_mode))
      msog_pkg::MODE_RASTER: begin
        if (c0 < n_s - SW'(1)) begin
          c = c0 + SW'(1);
        end else begin
          c = '0;
          r = r0 + SW'(1);
        end
      end
      msog_pkg::MODE_SNAKE: begin
        if (!cur_row[0]) begin
          if (c0 < n_s - SW'(1)) c = c0 + SW'(1);
          else r = r0 + SW'(1);
        end else begin
          if (c0 > SW'(0)) c = c0 - SW'(1);
          else r = r0 + SW'(1);
        end
      end
      msog_pkg::MODE_SPIRAL: begin
        if (hi < k0) begin
          ok = 1'b0;
        end else begin
          case (leg_phase)
            msog_pkg::PH_RIGHT: begin
              if (c0 < hi) c = c0 + SW'(1);
              else begin ph = msog_pkg::PH_DOWN; r = r0 + SW'(1); end
            end
            msog_pkg::PH_DOWN: begin
              if (r0 < hi) r = r0 + SW'(1);
              else begin ph = msog_pkg::PH_LEFT; c = c0 - SW'(1); end
            end
            msog_pkg::PH_LEFT: begin
              if (c0 > k0) c = c0 - SW'(1);
              else begin ph = msog_pkg::PH_UP; r = r0 - SW'(1); end
            end
            default: begin
              if (r0 > k0 + SW'(1)) r = r0 - SW'(1);
              else begin
                k  = k0 + SW'(1);
                ph = msog_pkg::PH_RIGHT;
                c  = c0 + SW'(1);
              end
            end
          endcase
        end
      end
      default: begin
        // Corner shells: the 2x2 block opens, then shells alternate direction.
        if (k0 <= SW'(1)) begin
          k  = SW'(2);
          ph = msog_pkg::PH_FIRST;
          r  = '0;
          c  = SW'(1);
        end else if (!ring_index[0]) begin
          if (leg_phase == msog_pkg::PH_FIRST) begin
            if (r0 < k0 - SW'(1)) r = r0 + SW'(1);
            else begin ph = msog_pkg::PH_SECOND; c = c0 - SW'(1); end
          end else begin
            if (c0 > SW'(0)) c = c0 - SW'(1);
            else begin
              k  = k0 + SW'(1);
              ph = msog_pkg::PH_FIRST;
              r  = k0;
              c  = '0;
            end
          end
        end else begin
          if (leg_phase == msog_pkg::PH_FIRST) begin
            if (c0 < k0 - SW'(1)) c = c0 + SW'(1);
            else begin ph = msog_pkg::PH_SECOND; r = r0 - SW'(1); end
          end else begin
            if (r0 > SW'(0)) r = r0 - SW'(1);
            else begin
              k  = k0 + SW'(1);
              ph = msog_pkg::PH_FIRST;
              r  = '0;
              c  = k0;
            end
          end
        end
      end
    endcase
    // Drop the move if it leaves the matrix or overflows the ring counter.
    if ((r < SW'(0)) || (c < SW'(0)) || (r >= n_s) || (c >= n_s) ||
        (k > SW'(2**msog_pkg::RING_W - 1))) begin
      ok = 1'b0;
    end
  end

  assign start = start_in || !ok;

  always_comb begin
    if (start) begin
      row_next   = '0;
      col_next   = '0;
      phase_next = msog_pkg::PH_RIGHT;
      ring_next  = '0;
      count_next = CW'(1);
    end else begin
      row_next   = r[ROW_W-1:0];
      col_next   = c[ROW_W-1:0];
      phase_next = ph;
      ring_next  = k[msog_pkg::RING_W-1:0];
      count_next = visit_count + CW'(1);
    end
  end

  assign last = (count_next == total);

endmodule

### rtl/matrix_scan_order_generator.sv
// ----------------------------------------------------------------------------
// matrix_scan_order_generator
// Emits one cell position of an n by n matrix per request, in raster, snake,
// clockwise spiral or corner-shell order.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the slave stream (s_tdata[0] = restart) produces exactly
//   one result on the master stream: row, column and visit number of the next
//   cell, with m_tlast set on the final cell of the scan. The request after
//   the final cell, or a request with restart set, begins at cell (0,0).
//   Side length and order are set through the APB port (0x0 matrix_size,
//   0x4 scan_mode) while the stream is idle.
//   Path: the request register loads at the accepting edge, and the
//   next-cell logic then loads the result register, which raises m_tvalid.
//   Throughput is one result per cycle while the receiver does not stall;
//   the state update of the walk is a single combinational step, so
//   requests may arrive every cycle while s_tready is high.
//   When the receiver stalls, the result register holds its value and the
//   request register fills; s_tready drops only once both are occupied.
//   Reset (synchronous, active high) empties both registers, restores size 8
//   and raster order, and leaves the walk unstarted so the first request
//   returns (0,0) with visit number 1.
// ----------------------------------------------------------------------------
`include "matrix_scan_order_generator_macros.svh"

module matrix_scan_order_generator #(
  parameter int MAX_SIZE = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msog_pkg::APB_AW-1:0]       paddr,
  input  logic [msog_pkg::APB_DW-1:0]       pwdata,
  output logic [msog_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] restart
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // fields from bit 0: row, col, order_value, zero fill
  output logic [((2*$clog2(MAX_SIZE)+$clog2(MAX_SIZE*MAX_SIZE+1)+7)/8)*8-1:0] m_tdata,
  output logic                              m_tlast    // last cell of the scan
);

  localparam int ROW_W = $clog2(MAX_SIZE);
  localparam int CW    = $clog2(MAX_SIZE * MAX_SIZE + 1);
  localparam int DW    = ((2 * ROW_W + CW + 7) / 8) * 8;

  logic [msog_pkg::SIZE_W-1:0] matrix_size;
  logic [msog_pkg::MODE_W-1:0] scan_mode;

  // Request register.
  logic                        in_valid;
  logic                        in_restart;
  logic                        fire;

  // Walk state.
  logic [ROW_W-1:0]            cur_row;
  logic [ROW_W-1:0]            cur_col;
  logic [1:0]                  leg_phase;
  logic [msog_pkg::RING_W-1:0] ring_index;
  logic [CW-1:0]               visit_count;

  logic [ROW_W-1:0]            row_next;
  logic [ROW_W-1:0]            col_next;
  logic [1:0]                  phase_next;
  logic [msog_pkg::RING_W-1:0] ring_next;
  logic [CW-1:0]               count_next;
  logic                        last_next;

  // Result register.
  logic [ROW_W-1:0]            out_row;
  logic [ROW_W-1:0]            out_col;
  logic [CW-1:0]               out_order;

  msog_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .matrix_size (matrix_size),
    .scan_mode   (scan_mode)
  );

  msog_step #(
    .MAX_SIZE (MAX_SIZE)
  ) u_step (
    .matrix_size (matrix_size),
    .scan_mode   (scan_mode),
    .restart     (in_restart),
    .cur_row     (cur_row),
    .cur_col     (cur_col),
    .leg_phase   (leg_phase),
    .ring_index  (ring_index),
    .visit_count (visit_count),
    .row_next    (row_next),
    .col_next    (col_next),
    .phase_next  (phase_next),
    .ring_next   (ring_next),
    .count_next  (count_next),
    .last        (last_next)
  );

  // Advance the held request whenever the result register is free or drains.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_restart <= s_tdata[0];
    end
  end

  // Commit the walk state together with the result it produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      leg_phase   <= msog_pkg::PH_RIGHT;
      ring_index  <= '0;
      visit_count <= '0;
    end else if (fire) begin
      cur_row     <= row_next;
      cur_col     <= col_next;
      leg_phase   <= phase_next;
      ring_index  <= ring_next;
      visit_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the payload while the receiver stalls.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_row   <= row_next;
      out_col   <= col_next;
      out_order <= count_next;
      m_tlast   <= last_next;
    end
  end

  assign m_tdata = DW'({out_order, out_col, out_row});

  // A visit number is never zero once a cell is shown.
  `MSOG_ASSERT_IMPL(a_order_nonzero, clk, rst, m_tvalid, out_order != '0,
    "result with visit number zero")
  // The first visit of a scan is always the corner cell.
  `MSOG_ASSERT_IMPL(a_first_is_corner, clk, rst, m_tvalid && (out_order == CW'(1)),
    (out_row == '0) && (out_col == '0), "first visit not at cell (0,0)")
  // The shown result and the walk count move together.
  `MSOG_ASSERT_IMPL(a_count_matches, clk, rst, m_tvalid, visit_count == out_order,
    "walk count differs from shown visit number")
  // A held request always moves into an empty result register.
  `MSOG_ASSERT_NEXT(a_request_moves, clk, rst, in_valid && !m_tvalid, m_tvalid,
    "held request did not reach the result register")

endmodule
